// ===== hdl/awsm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awsm_pkg: shared types and defaults of the adaptive weighted smoother
// Sample and fraction width defaults, and the control bundle that drives the
// serial divider and the serial multiply-accumulate.
// ---------------------------------------------------------------------------
package awsm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // load: take fresh operands; step: advance one quotient bit
    typedef struct packed {
        logic load;
        logic step;
    } step_ctrl_t;

endpackage

// ===== hdl/awsm_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awsm_divider: bit-serial restoring divider
// Emits the weight diff * 2^FRAC_BITS / sum one quotient bit per cycle of step, MSB
// first, FRAC_BITS + 1 bits in all. A zero divisor yields an all-zero weight.
// ---------------------------------------------------------------------------
module awsm_divider #(
    parameter int SAMPLE_WIDTH = awsm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  awsm_pkg::step_ctrl_t    ctrl,
    input  logic [SAMPLE_WIDTH:0]   dividend,
    input  logic [SAMPLE_WIDTH:0]   divisor,
    output logic                    q_bit
);

    logic [SAMPLE_WIDTH+1:0] rem_reg;
    logic [SAMPLE_WIDTH+1:0] rem_next;
    logic [SAMPLE_WIDTH:0]   den_reg;
    logic                    zero_reg;
    logic                    ge;
    logic [SAMPLE_WIDTH+1:0] diff_rem;

    assign ge       = rem_reg >= {1'b0, den_reg};
    assign diff_rem = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign q_bit    = ge & ~zero_reg;

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load) begin
            rem_next = {1'b0, dividend};
        end else if (ctrl.step) begin
            // remainder stays below the divisor, so the shift never overflows
            rem_next = {diff_rem[SAMPLE_WIDTH:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (ctrl.load) begin
            den_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
    end

endmodule

// ===== hdl/awsm_serial_mac.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awsm_serial_mac: serial weighting and rounding
// Builds (p - x) * d from the quotient bits, MSB first, then forms
// x * 2^F + (p - x) * d + half and truncates toward zero to a sample.
// ---------------------------------------------------------------------------
module awsm_serial_mac #(
    parameter int SAMPLE_WIDTH = awsm_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = awsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  awsm_pkg::step_ctrl_t            ctrl,
    input  logic                            q_bit,
    input  logic signed [SAMPLE_WIDTH-1:0]  x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]  p_in,
    output logic signed [SAMPLE_WIDTH-1:0]  y_out
);

    localparam int AW = SAMPLE_WIDTH + FRAC_BITS + 2;

    logic signed [AW-1:0]           acc_reg;
    logic signed [AW-1:0]           acc_next;
    logic signed [SAMPLE_WIDTH:0]   e_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [AW-1:0]           num;
    logic signed [AW-1:0]           quo;
    logic                           frac_nz;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.load) begin
            acc_next = '0;
        end else if (ctrl.step) begin
            acc_next = (acc_reg <<< 1) + (q_bit ? AW'(e_reg) : AW'(0));
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (ctrl.load) begin
            x_reg <= x_in;
            e_reg <= (SAMPLE_WIDTH+1)'(p_in) - (SAMPLE_WIDTH+1)'(x_in);
        end
    end

    assign num     = acc_reg + (AW'(x_reg) <<< FRAC_BITS) + (AW'(1) <<< (FRAC_BITS - 1));
    assign quo     = num >>> FRAC_BITS;
    assign frac_nz = |num[FRAC_BITS-1:0];
    // truncate toward zero: bump negative values that lost a fraction
    assign y_out   = SAMPLE_WIDTH'(quo + ((num[AW-1] && frac_nz) ? AW'(1) : AW'(0)));

endmodule

// ===== hdl/adaptive_weighted_smoother_unit.sv =====
`timescale 1ns / 1ps
// Sequence: an accepted word steps through ST_CALC, one weight bit per cycle
//   from the bit-serial divider, then waits in ST_FINAL for a free output;
//   a block-start word goes straight to ST_FINAL and passes through unchanged.
// No new word is accepted until the last has gone to the output register.
// Reset: synchronous, active-low aresetn clears control and the previous output.
// ---------------------------------------------------------------------------
// adaptive_weighted_smoother_unit: adaptive weighted smoother top level
// Weights each sample against the previous output by |x-p| / (|x|+|p|) and
// blends the two; the first word of a block passes through unchanged.
// ---------------------------------------------------------------------------
module adaptive_weighted_smoother_unit #(
    parameter int SAMPLE_WIDTH = awsm_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = awsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_sample,
    input  logic                            s_block_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  m_smoothed
);

    localparam int CW = $clog2(FRAC_BITS + 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           start_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_data_reg;

    logic                           accept;
    logic                           emit;
    awsm_pkg::step_ctrl_t           ctrl;
    logic                           q_bit;
    logic signed [SAMPLE_WIDTH-1:0] mac_y;
    logic signed [SAMPLE_WIDTH-1:0] result;

    logic signed [SAMPLE_WIDTH:0]   x_ext, p_ext, x_minus_p;
    logic [SAMPLE_WIDTH:0]          abs_x, abs_p, abs_diff, abs_sum;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_smoothed = m_data_reg;

    // operands of the weight, formed from the word being accepted
    assign x_ext     = (SAMPLE_WIDTH+1)'(s_sample);
    assign p_ext     = (SAMPLE_WIDTH+1)'(prev_reg);
    assign x_minus_p = x_ext - p_ext;
    assign abs_x     = x_ext[SAMPLE_WIDTH] ? -x_ext : x_ext;
    assign abs_p     = p_ext[SAMPLE_WIDTH] ? -p_ext : p_ext;
    assign abs_diff  = x_minus_p[SAMPLE_WIDTH] ? -x_minus_p : x_minus_p;
    assign abs_sum   = abs_x + abs_p;

    // load both serial units on every accept; a block-start word ignores them
    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == ST_CALC);

    awsm_divider #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .dividend (abs_diff),
        .divisor  (abs_sum),
        .q_bit    (q_bit)
    );

    awsm_serial_mac #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .q_bit (q_bit),
        .x_in  (s_sample),
        .p_in  (prev_reg),
        .y_out (mac_y)
    );

    assign result = start_reg ? x_reg : mac_y;
    // hand the word to the output register once it is free
    assign emit   = (state_reg == ST_FINAL) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    state_next = s_block_start ? ST_FINAL : ST_CALC;
                end
            end
            ST_CALC: begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            prev_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (emit) begin
                prev_reg <= result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= s_sample;
            start_reg <= s_block_start;
        end
        if (emit) begin
            m_data_reg <= result;
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for adaptive_weighted_smoother_unit
// Streams signed sample words through the smoother, predicts every smoothed
// word in the bench and checks the output stream in order, under changing
// sender and receiver pacing and one long output stall.
// ---------------------------------------------------------------------------
module testbench;

    localparam int SW         = awsm_pkg::SAMPLE_WIDTH_DEF;
    localparam int FB         = awsm_pkg::FRAC_BITS_DEF;
    localparam longint ONE    = longint'(1) << FB;
    localparam longint HALF   = longint'(1) << (FB - 1);
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = FB + 20;
    localparam int STALL_LEN  = 300;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 block_start;
    } sample_word_t;

    // DUT ports; every input starts at a known value
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic signed [SW-1:0]  s_sample      = '0;
    logic                  s_block_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic signed [SW-1:0]  m_smoothed;

    // stimulus and scoreboard state
    sample_word_t          pending_words[$];
    logic signed [SW-1:0]  smooth_expect[$];
    logic signed [SW-1:0]  last_smoothed = '0;   // bench copy of the previous output
    logic signed [SW-1:0]  smooth_want;
    logic                  in_taken      = 1'b0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    stall_requests = 0;
    int                    stalls_served  = 0;
    int                    stall_left     = 0;
    int                    words_queued   = 0;
    int                    words_accepted = 0;
    int                    words_checked  = 0;
    int                    starts_sent    = 0;
    int                    backpressure_cycles = 0;
    int                    fail_count     = 0;
    int                    cycle_count    = 0;

    adaptive_weighted_smoother_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_block_start (s_block_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_smoothed    (m_smoothed)
    );

    // 4 ns clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hold reset low at start, then release it on a falling edge.
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Blend one sample against the previous output.
    // The weight is |x-p| / (|x|+|p|) in FB fraction bits, truncated and capped
    // at one; the blend adds one half and truncates toward zero, so negative
    // results round up rather than symmetrically.
    function automatic logic signed [SW-1:0] blend_sample(
        input logic signed [SW-1:0] x_in,
        input logic signed [SW-1:0] p_in,
        input logic                 start
    );
        longint x;
        longint p;
        longint diff;
        longint total;
        longint weight;
        longint num;
        longint y;
        x = longint'(x_in);
        p = longint'(p_in);
        if (start) begin
            y = x;
        end else begin
            diff   = (x >= p) ? (x - p) : (p - x);
            total  = ((x < 0) ? -x : x) + ((p < 0) ? -p : p);
            weight = 0;
            if (total != 0) begin
                weight = (diff << FB) / total;
            end
            if (weight > ONE) begin
                weight = ONE;
            end
            num = x * (ONE - weight) + p * weight + HALF;
            y   = num / ONE;   // signed division truncates toward zero
        end
        return y[SW-1:0];
    endfunction

    // Sender: present words at the falling edge; hold a word until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold: word still waiting for ready
        end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s_valid       <= 1'b1;
            s_sample      <= pending_words[0].sample;
            s_block_start <= pending_words[0].block_start;
            void'(pending_words.pop_front());
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random ready, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_served < stall_requests) begin
            m_ready       <= 1'b0;
            stall_left    <= STALL_LEN;
            stalls_served <= stalls_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: on each rising edge, predict accepted input words and check
    // delivered output words against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && !s_ready) begin
                backpressure_cycles++;
            end
            if (s_valid && s_ready) begin
                last_smoothed = blend_sample(s_sample, last_smoothed, s_block_start);
                smooth_expect.push_back(last_smoothed);
                words_accepted++;
                if (s_block_start) begin
                    starts_sent++;
                end
            end
            if (m_valid && m_ready) begin
                if (smooth_expect.size() == 0) begin
                    $error("smoothed: unexpected word, expected none, actual %0d", m_smoothed);
                    fail_count++;
                end else begin
                    smooth_want = smooth_expect.pop_front();
                    words_checked++;
                    if (m_smoothed !== smooth_want) begin
                        $error("smoothed mismatch: expected %0d, actual %0d",
                               smooth_want, m_smoothed);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if it stalls far beyond the slowest correct run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, smooth_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_word(input logic signed [SW-1:0] value, input logic start);
        sample_word_t w;
        w.sample      = value;
        w.block_start = start;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Random words: mostly a slow random walk (the typical sensor signal),
    // plus full-range noise and extremes; about one word in ten opens a block.
    task automatic queue_random_words(input int count);
        int                   walk;
        int                   pick;
        logic signed [SW-1:0] value;
        logic                 start;
        walk = 0;
        for (int k = 0; k < count; k++) begin
            start = ($urandom_range(99) < 10);
            pick  = $urandom_range(9);
            if (pick == 0) begin
                case ($urandom_range(4))
                    0:       value = {1'b0, {(SW-1){1'b1}}};
                    1:       value = {1'b1, {(SW-1){1'b0}}};
                    2:       value = '0;
                    3:       value = '1;
                    default: value = SW'(1);
                endcase
            end else if (pick < 4) begin
                value = SW'($urandom);
            end else begin
                walk = walk + int'($urandom_range(400)) - 200;
                if (walk > 32767) walk = 32767;
                if (walk < -32768) walk = -32768;
                value = SW'(walk);
            end
            walk = int'(value);
            push_word(value, start);
        end
    endtask

    // Wait until every queued word is accepted and every result has arrived.
    task automatic drain_words();
        while (words_accepted < words_queued || smooth_expect.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        wait (aresetn);

        // Phase one: sender idles rarely, receiver idles mostly.
        send_idle_pct = 18;
        recv_idle_pct = 82;

        // Directed words. No block start yet, so the smoother runs with p = 0:
        // one operand zero gives full weight to p, both zero gives weight 0.
        push_word(SW'(100), 1'b0);
        push_word(SW'(0), 1'b0);
        push_word(SW'(-7), 1'b0);
        // positive extreme, then steady, then opposite sign
        push_word(SW'(32767), 1'b1);
        push_word(SW'(32767), 1'b0);
        push_word(SW'(-32768), 1'b0);
        // negative extreme; opposite sign lands on -32767.5, truncated up
        push_word(SW'(-32768), 1'b1);
        push_word(SW'(-32768), 1'b0);
        push_word(SW'(32767), 1'b0);
        push_word(SW'(-1), 1'b0);
        // block starting at zero, then small negatives
        push_word(SW'(0), 1'b1);
        push_word(SW'(-5), 1'b0);
        push_word(SW'(-1), 1'b1);
        push_word(SW'(-3), 1'b0);
        // ordinary blends, positive and negative
        push_word(SW'(1000), 1'b1);
        push_word(SW'(1200), 1'b0);
        push_word(SW'(1100), 1'b0);
        push_word(SW'(-300), 1'b1);
        push_word(SW'(-250), 1'b0);
        push_word(SW'(-320), 1'b0);
        // alternating bit patterns
        push_word(16'sh5555, 1'b1);
        push_word(16'shAAAA, 1'b0);
        push_word(16'shAAAA, 1'b1);
        push_word(16'sh5555, 1'b0);
        queue_random_words(260);
        drain_words();

        // Phase two: sender idles mostly, receiver rarely.
        send_idle_pct = 82;
        recv_idle_pct = 18;
        queue_random_words(260);
        drain_words();

        // Phase three: no idling, with one long output hold-off up front so the
        // block fills and drops s_ready while words keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        queue_random_words(260);
        drain_words();

        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d words (%0d block starts) over three pacing phases,",
                 words_accepted, starts_sent);
        $display("checked %0d smoothed words; input held off for %0d cycles",
                 words_checked, backpressure_cycles);
        if (fail_count == 0 && smooth_expect.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/awsm_pkg.sv
hdl/awsm_divider.sv
hdl/awsm_serial_mac.sv
hdl/adaptive_weighted_smoother_unit.sv
sim/testbench.sv
